>>> rtl/core/idq_pkg.sv
// shared types, constants and fp32/bf16 arithmetic helpers for the dequant dot product
package idq_pkg;

    localparam int IDQ_QDEPTH = 2;

    localparam logic [3:0]  CODE_OFFSET   = 4'd8;
    localparam logic [31:0] F32_QNAN      = 32'h7fc0_0000;
    localparam logic [31:0] F32_INF_BITS  = 32'h7f80_0000;
    localparam logic [15:0] BF16_QNAN     = 16'h7fc0;

    typedef struct packed {
        logic [15:0] activation;
        logic [3:0]  weight_code;
        logic [31:0] group_scale;
        logic [31:0] bias_value;
        logic        last;
        logic        add_bias;
    } item_t;

    // value = mag * 2^(exp - 127 - 47) unless special
    typedef struct packed {
        logic               special;
        logic [31:0]        spec_val;
        logic               sign;
        logic signed [10:0] exp;
        logic [48:0]        mag;
    } fp_mid_t;

    function automatic logic is_nan(input logic [31:0] a);
        return (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] a);
        return a[30:0] == F32_INF_BITS[30:0];
    endfunction

    function automatic logic is_zero(input logic [31:0] a);
        return a[30:0] == 31'd0;
    endfunction

    function automatic logic [23:0] f32_mant(input logic [31:0] a);
        return {(a[30:23] != 8'd0), a[22:0]};
    endfunction

    function automatic logic signed [10:0] f32_exp(input logic [31:0] a);
        return (a[30:23] == 8'd0) ? 11'sd1 : signed'({3'b000, a[30:23]});
    endfunction

    function automatic logic [15:0] f32_to_bf16(input logic [31:0] b);
        logic [31:0] t;
        t = b + 32'h0000_7fff + {31'd0, b[16]};
        if (b[30:0] > F32_INF_BITS[30:0])
            return BF16_QNAN;
        return t[31:16];
    endfunction

    // exact fp32 of (code - 8)
    function automatic logic [31:0] code_to_f32(input logic [3:0] c);
        logic       neg;
        logic [3:0] mag;
        logic [7:0] ex;
        logic [2:0] fr;
        neg = c < CODE_OFFSET;
        mag = neg ? (CODE_OFFSET - c) : (c - CODE_OFFSET);
        ex  = 8'd0;
        fr  = 3'd0;
        case (mag)
            4'd1: begin ex = 8'd127; fr = 3'b000; end
            4'd2: begin ex = 8'd128; fr = 3'b000; end
            4'd3: begin ex = 8'd128; fr = 3'b100; end
            4'd4: begin ex = 8'd129; fr = 3'b000; end
            4'd5: begin ex = 8'd129; fr = 3'b010; end
            4'd6: begin ex = 8'd129; fr = 3'b100; end
            4'd7: begin ex = 8'd129; fr = 3'b110; end
            4'd8: begin ex = 8'd130; fr = 3'b000; end
            default: begin ex = 8'd0; fr = 3'b000; end
        endcase
        return {neg, ex, fr, 20'd0};
    endfunction

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        n = 6'd0;
        for (int i = 0; i < 48; i++)
            if (v[i])
                n = 6'(47 - i);
        return n;
    endfunction

    // first half of a multiply: specials, exponent sum and mantissa product
    function automatic fp_mid_t f32_mul_pre(input logic [31:0] a, input logic [31:0] b);
        fp_mid_t     m;
        logic [47:0] p;
        m = '0;
        m.sign = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b) || (is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b)))
        begin
            m.special  = 1'b1;
            m.spec_val = F32_QNAN;
        end
        else if (is_inf(a) || is_inf(b))
        begin
            m.special  = 1'b1;
            m.spec_val = {m.sign, F32_INF_BITS[30:0]};
        end
        else if (is_zero(a) || is_zero(b))
        begin
            m.special  = 1'b1;
            m.spec_val = {m.sign, 31'd0};
        end
        p     = {24'd0, f32_mant(a)} * {24'd0, f32_mant(b)};
        m.exp = f32_exp(a) + f32_exp(b) - 11'sd126;
        m.mag = {1'b0, p};
        return m;
    endfunction

    // first half of an add: specials, swap, align with sticky, add or subtract
    function automatic fp_mid_t f32_add_pre(input logic [31:0] a, input logic [31:0] b);
        fp_mid_t            m;
        logic               swap;
        logic [31:0]        big;
        logic [31:0]        sml;
        logic signed [10:0] eb;
        logic signed [10:0] es;
        logic [10:0]        d;
        logic [48:0]        x;
        logic [48:0]        yf;
        logic [48:0]        y;
        logic [48:0]        mask;
        m    = '0;
        swap = b[30:0] > a[30:0];
        big  = swap ? b : a;
        sml  = swap ? a : b;
        eb   = f32_exp(big);
        es   = f32_exp(sml);
        d    = 11'(eb - es);
        x    = {1'b0, f32_mant(big), 24'd0};
        yf   = {1'b0, f32_mant(sml), 24'd0};
        y    = yf >> d;
        mask = ~({49{1'b1}} << d);
        y[0] = y[0] | (|(yf & mask));
        m.sign = big[31];
        m.exp  = eb;
        m.mag  = (big[31] ^ sml[31]) ? (x - y) : (x + y);
        if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && (a[31] != b[31])))
        begin
            m.special  = 1'b1;
            m.spec_val = F32_QNAN;
        end
        else if (is_inf(a))
        begin
            m.special  = 1'b1;
            m.spec_val = a;
        end
        else if (is_inf(b))
        begin
            m.special  = 1'b1;
            m.spec_val = b;
        end
        else if (is_zero(a) && is_zero(b))
        begin
            m.special  = 1'b1;
            m.spec_val = {a[31] & b[31], 31'd0};
        end
        else if (is_zero(a))
        begin
            m.special  = 1'b1;
            m.spec_val = b;
        end
        else if (is_zero(b))
        begin
            m.special  = 1'b1;
            m.spec_val = a;
        end
        return m;
    endfunction

    // second half: normalize, denormalize if tiny, round to nearest even
    function automatic logic [31:0] f32_finish(input fp_mid_t m);
        logic [5:0]         lz;
        logic [47:0]        nm;
        logic signed [10:0] e;
        logic [10:0]        sh;
        logic [47:0]        mm;
        logic [47:0]        lmask;
        logic               lost;
        logic               up;
        logic [7:0]         fld;
        logic [30:0]        pk;
        if (m.special)
            return m.spec_val;
        if (m.mag == 49'd0)
            return 32'd0;
        lz = 6'd0;
        if (m.mag[48])
        begin
            nm = {m.mag[48:2], |m.mag[1:0]};
            e  = m.exp + 11'sd1;
        end
        else
        begin
            lz = lzc48(m.mag[47:0]);
            nm = m.mag[47:0] << lz;
            e  = m.exp - signed'({5'd0, lz});
        end
        if (e >= 11'sd255)
            return {m.sign, F32_INF_BITS[30:0]};
        if (e >= 11'sd1)
        begin
            sh  = 11'd0;
            fld = e[7:0];
        end
        else
        begin
            sh  = 11'(11'sd1 - e);
            fld = 8'd0;
        end
        mm    = nm >> sh;
        lmask = ~({48{1'b1}} << sh);
        lost  = |(nm & lmask);
        up    = mm[23] & (lost | (|mm[22:0]) | mm[24]);
        pk    = {fld, mm[46:24]} + {30'd0, up};
        return {m.sign, pk};
    endfunction

endpackage

>>> rtl/core/idq_front.sv
// input side: accepts items, tags bias use, holds them in a short queue for the back end
module idq_front
    import idq_pkg::*;
#(
    parameter int QDEPTH = IDQ_QDEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] activation,
    input  logic [3:0]  weight_code,
    input  logic [31:0] group_scale,
    input  logic [31:0] bias_value,
    input  logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_pop
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    item_t          mem_reg [QDEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           bias_en_reg;
    logic           wr_en;
    logic           rd_en;
    item_t          in_item;

    assign cfg_ready = 1'b1;
    assign full      = count_reg == CW'(QDEPTH);
    assign q_valid   = count_reg != '0;
    assign q_item    = mem_reg[rd_ptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = q_pop && q_valid;

    always_comb
    begin
        in_item.activation  = activation;
        in_item.weight_code = weight_code;
        in_item.group_scale = group_scale;
        in_item.bias_value  = bias_value;
        in_item.last        = last;
        in_item.add_bias    = last && bias_en_reg;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
            bias_en_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            if (cfg_valid && cfg_ready)
                bias_en_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= in_item;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QDEPTH))
        else $error("queue count beyond depth");

    a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !rd_en) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |=> bias_en_reg == $past(cfg_data))
        else $error("bias enable not updated by config transfer");

endmodule

>>> rtl/core/idq_back.sv
// back end: dequantize, multiply, accumulate in fp32, optional bias, bf16 result register
module idq_back
    import idq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] result_value
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_WMUL1 = 10'b00_0000_0010,
        S_WMUL2 = 10'b00_0000_0100,
        S_PMUL1 = 10'b00_0000_1000,
        S_PMUL2 = 10'b00_0001_0000,
        S_ADD1  = 10'b00_0010_0000,
        S_ADD2  = 10'b00_0100_0000,
        S_BADD1 = 10'b00_1000_0000,
        S_BADD2 = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    item_t       item_reg;
    logic [31:0] wgt_reg;
    logic [31:0] prod_reg;
    logic [31:0] sum_reg;
    fp_mid_t     mul_mid_reg;
    fp_mid_t     add_mid_reg;
    logic        out_valid_reg;
    logic [15:0] out_data_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] mul_res;
    logic [31:0] add_b;
    logic [31:0] add_res;
    logic        out_free;
    logic        take;

    assign empty        = !out_valid_reg;
    assign result_value = out_data_reg;
    assign out_free     = !out_valid_reg || pop;

    // next item is taken when idle, after a non-last accumulate, or as a result leaves
    always_comb
    begin
        take = 1'b0;
        unique case (state_reg)
            S_IDLE:  take = 1'b1;
            S_ADD2:  take = !item_reg.last;
            S_OUT:   take = out_free;
            default: take = 1'b0;
        endcase
    end
    assign q_pop = q_valid && take;

    always_comb
    begin
        mul_a = (state_reg == S_WMUL1) ? code_to_f32(item_reg.weight_code)
                                       : {item_reg.activation, 16'd0};
        mul_b = (state_reg == S_WMUL1) ? item_reg.group_scale : wgt_reg;
        add_b = (state_reg == S_BADD1) ? item_reg.bias_value : prod_reg;
        mul_res = f32_finish(mul_mid_reg);
        add_res = f32_finish(add_mid_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  state_next = q_valid ? S_WMUL1 : S_IDLE;
            S_WMUL1: state_next = S_WMUL2;
            S_WMUL2: state_next = S_PMUL1;
            S_PMUL1: state_next = S_PMUL2;
            S_PMUL2: state_next = S_ADD1;
            S_ADD1:  state_next = S_ADD2;
            S_ADD2:
            begin
                if (item_reg.last)
                    state_next = item_reg.add_bias ? S_BADD1 : S_OUT;
                else
                    state_next = q_valid ? S_WMUL1 : S_IDLE;
            end
            S_BADD1: state_next = S_BADD2;
            S_BADD2: state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                    state_next = q_valid ? S_WMUL1 : S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_ADD2 || state_reg == S_BADD2)
                sum_reg <= add_res;
            else if (state_reg == S_OUT && out_free)
                sum_reg <= 32'd0;
            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_mid_reg <= f32_mul_pre(mul_a, mul_b);
        add_mid_reg <= f32_add_pre(sum_reg, add_b);
        if (q_pop)
            item_reg <= q_item;
        // weight goes through bf16 before use
        if (state_reg == S_WMUL2)
            wgt_reg <= {f32_to_bf16(mul_res), 16'd0};
        if (state_reg == S_PMUL2)
            prod_reg <= mul_res;
        if (state_reg == S_OUT && out_free)
            out_data_reg <= f32_to_bf16(sum_reg);
    end

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !out_valid_reg) |=> (out_valid_reg && sum_reg == 32'd0))
        else $error("result not loaded or sum not cleared");

    a_pop_when: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE || state_reg == S_ADD2 || state_reg == S_OUT))
        else $error("item taken while back end busy");

endmodule

>>> rtl/core/int4_group_dequant_dot_product_unit.sv
// top level of the int4 group-dequant dot product unit
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------------------
//  input    | push / full             | activation, weight_code, group_scale, bias_value, last
//  result   | pop / empty             | result_value
//  config   | cfg_valid / cfg_ready   | cfg_data (bias enable)
//
// per item the back end does weight multiply and bf16 rounding (WMUL1, WMUL2), activation
// multiply (PMUL1, PMUL2) and fp32 accumulate (ADD1, ADD2), with shared mul and add units
// a last item loads the result register in S_OUT, after S_BADD1 and S_BADD2 when bias is added
// the input queue holds two items, so the feeder can run ahead while the back end works
// reset empties the queue, clears the running sum, the bias enable and the result valid flag
// a full result register stalls the back end in its output step until the result transfer
module int4_group_dequant_dot_product_unit
    import idq_pkg::*;
#(
    parameter int QDEPTH = IDQ_QDEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] activation,
    input  logic [3:0]  weight_code,
    input  logic [31:0] group_scale,
    input  logic [31:0] bias_value,
    input  logic        last,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] result_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    idq_front #(
        .QDEPTH (QDEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .activation  (activation),
        .weight_code (weight_code),
        .group_scale (group_scale),
        .bias_value  (bias_value),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    idq_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .result_value (result_value)
    );

endmodule
